// File: rtl/rsa_pkg.sv
// Shared types and codes for the reference-counted setting arbiter.
// No dependencies; used by rsa_table and refcounted_setting_arbiter.
package rsa_pkg;

	localparam int unsigned TABLE_ENTRIES = 16;

	localparam logic [1:0] KIND_REQUEST = 2'd0;
	localparam logic [1:0] KIND_RELEASE = 2'd1;
	localparam logic [1:0] KIND_RESET   = 2'd2;

	localparam logic [1:0] SET_DEFAULT  = 2'd0;
	localparam logic [1:0] SET_ENABLED  = 2'd1;
	localparam logic [1:0] SET_DISABLED = 2'd2;
	localparam logic [1:0] SET_ERROR    = 2'd3;

	localparam logic [2:0] RC_OK       = 3'd0;
	localparam logic [2:0] RC_BADARG   = 3'd1;
	localparam logic [2:0] RC_INVSTATE = 3'd2;
	localparam logic [2:0] RC_INUSE    = 3'd3;
	localparam logic [2:0] RC_ILLEGAL  = 3'd4;
	localparam logic [2:0] RC_NOROOM   = 3'd5;
	localparam logic [2:0] RC_XFAIL    = 3'd6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SCAN,
		ST_EVAL,
		ST_NOTE,
		ST_FINAL
	} seq_state_t;

	// one write to the requester table
	typedef struct packed {
		logic        en;
		logic        set_valid;
		logic        clr_valid;
		logic [63:0] key;
		logic [31:0] refs;
	} tbl_wr_t;

endpackage

// File: rtl/refcounted_setting_arbiter.sv
// Request and release walk the table once from accept to final result; an item rejected at
// dispatch (bad argument, error state, in use) goes straight to the final result.
// Reset with k valid requesters walks the table k+1 times; a forced request adds that reset
// to its own lookup. Every table walk reads one entry per cycle through one read port.
// One request is in flight at a time; s_axis_tready is high only when the sequencer is idle.
// arst_n empties the table, sets the setting to default, the total to 0, allow_recursive to 0.
module refcounted_setting_arbiter #(
	parameter int unsigned TABLE_ENTRIES = rsa_pkg::TABLE_ENTRIES
) (
	input  logic          clk,
	input  logic          arst_n,
	// config register: allow_recursive
	input  logic          cfg_wr_en,
	input  logic          cfg_wr_data,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	// [63:0] requester_id, [65:64] requested_state, [66] force_req,
	// [67] release_all, [68] force_callback, [69] transition_ok, rest zero
	input  logic [71:0]   s_axis_tdata,
	// [1:0] kind
	input  logic [1:0]    s_axis_tuser,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// [63:0] evicted_requester, [66:64] status, [68:67] setting_state,
	// [100:69] total_refs, rest zero
	output logic [103:0]  m_axis_tdata,
	// [0] notice
	output logic          m_axis_tuser,
	output logic          m_axis_tlast
);

	localparam int unsigned AW = $clog2(TABLE_ENTRIES);
	localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CW-1:0] CNT_END = CW'(TABLE_ENTRIES);

	rsa_pkg::seq_state_t state_q, state_d;

	// captured request
	logic [1:0]  kind_q;
	logic [63:0] id_q;
	logic [1:0]  want_q;
	logic        force_q, all_q, fcb_q, tok_q;
	logic        allow_q;

	// arbiter state
	logic [1:0]  cur_q, cur_d;
	logic [31:0] total_q, total_d;
	logic [2:0]  err_q, err_d, st_q, st_d;

	// table walk
	logic [CW-1:0] cnt_q;
	logic          pend_s1;
	logic [AW-1:0] idx_s1;
	logic          min_mode_q, min_mode_d, have_lo_q, have_lo_d, from_req_q, from_req_d;
	logic [63:0]   lo_q, lo_d;
	logic          hit_q, free_q;
	logic [AW-1:0] hit_idx_q, free_idx_q;
	logic [63:0]   hit_key_q;
	logic [31:0]   hit_refs_q;

	logic [63:0] rd_key;
	logic [31:0] rd_refs;
	logic        rd_valid;
	rsa_pkg::tbl_wr_t wr;
	logic [AW-1:0] wr_addr;

	// output register
	logic          out_v_q, out_notice_q, out_last_q;
	logic [63:0]   out_id_q;
	logic [2:0]    out_st_q;
	logic [1:0]    out_set_q;
	logic [31:0]   out_tot_q;
	logic          out_free;

	// decisions
	logic        want_ok, conflict, go_reset, go_scan, start_scan;
	logic [2:0]  disp_st;
	logic [1:0]  rs_cur;
	logic [2:0]  rs_err;
	logic        rs_cont;
	logic [31:0] adj, rel_total, rel_refs;
	logic        rel_ok;

	rsa_table #(.ENTRIES(TABLE_ENTRIES)) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (cnt_q[AW-1:0]),
		.rd_key  (rd_key),
		.rd_refs (rd_refs),
		.rd_valid(rd_valid),
		.wr_addr (wr_addr),
		.wr      (wr)
	);

	assign out_free = !out_v_q || m_axis_tready;

	// dispatch and end-of-reset decisions
	always_comb begin
		want_ok  = (want_q == rsa_pkg::SET_ENABLED) || (want_q == rsa_pkg::SET_DISABLED);
		conflict = (total_q != 32'd0) && (want_q != cur_q);
		go_reset = (kind_q == rsa_pkg::KIND_RESET) ||
			((kind_q == rsa_pkg::KIND_REQUEST) && want_ok &&
			 (cur_q != rsa_pkg::SET_ERROR) && conflict && force_q);
		go_scan  = ((kind_q == rsa_pkg::KIND_RELEASE) && (cur_q != rsa_pkg::SET_ERROR)) ||
			((kind_q == rsa_pkg::KIND_REQUEST) && want_ok &&
			 (cur_q != rsa_pkg::SET_ERROR) && !conflict);
		priority if (kind_q == rsa_pkg::KIND_RELEASE) begin
			disp_st = rsa_pkg::RC_INVSTATE;
		end else if (kind_q != rsa_pkg::KIND_REQUEST) begin
			disp_st = rsa_pkg::RC_BADARG;
		end else if (!want_ok) begin
			disp_st = rsa_pkg::RC_BADARG;
		end else if (cur_q == rsa_pkg::SET_ERROR) begin
			disp_st = rsa_pkg::RC_INVSTATE;
		end else begin
			disp_st = rsa_pkg::RC_INUSE;
		end
		// wrap-up of a reset walk: leftover refs mean the books are off
		rs_cur = cur_q;
		rs_err = err_q;
		if (total_q != 32'd0) begin
			rs_cur = rsa_pkg::SET_ERROR;
			rs_err = rsa_pkg::RC_INVSTATE;
		end
		if (fcb_q && !from_req_q && rs_err == rsa_pkg::RC_OK) begin
			if (tok_q) begin
				rs_cur = rsa_pkg::SET_DEFAULT;
			end else begin
				rs_cur = rsa_pkg::SET_ERROR;
				rs_err = rsa_pkg::RC_XFAIL;
			end
		end
		rs_cont = from_req_q && (rs_err == rsa_pkg::RC_OK);
		// release arithmetic
		adj       = all_q ? hit_refs_q : 32'd1;
		rel_ok    = total_q >= adj;
		rel_total = total_q - adj;
		rel_refs  = hit_refs_q - adj;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rsa_pkg::ST_IDLE: begin
				if (s_axis_tvalid) state_d = rsa_pkg::ST_DISPATCH;
			end
			rsa_pkg::ST_DISPATCH: begin
				state_d = (go_reset || go_scan) ? rsa_pkg::ST_SCAN : rsa_pkg::ST_FINAL;
			end
			rsa_pkg::ST_SCAN: begin
				if (cnt_q == CNT_END) state_d = rsa_pkg::ST_EVAL;
			end
			rsa_pkg::ST_EVAL: begin
				if (min_mode_q && hit_q) begin
					state_d = rsa_pkg::ST_NOTE;
				end else if (min_mode_q && rs_cont) begin
					state_d = rsa_pkg::ST_SCAN;
				end else begin
					state_d = rsa_pkg::ST_FINAL;
				end
			end
			rsa_pkg::ST_NOTE: begin
				if (out_free) state_d = rsa_pkg::ST_SCAN;
			end
			rsa_pkg::ST_FINAL: begin
				if (out_free) state_d = rsa_pkg::ST_IDLE;
			end
			default: state_d = rsa_pkg::ST_IDLE;
		endcase
	end

	// register updates and table writes
	always_comb begin
		cur_d      = cur_q;
		total_d    = total_q;
		err_d      = err_q;
		st_d       = st_q;
		min_mode_d = min_mode_q;
		have_lo_d  = have_lo_q;
		from_req_d = from_req_q;
		lo_d       = lo_q;
		start_scan = 1'b0;
		wr         = '0;
		wr_addr    = hit_idx_q;
		unique case (state_q)
			rsa_pkg::ST_DISPATCH: begin
				start_scan = go_reset || go_scan;
				min_mode_d = go_reset;
				have_lo_d  = 1'b0;
				err_d      = rsa_pkg::RC_OK;
				from_req_d = kind_q == rsa_pkg::KIND_REQUEST;
				st_d       = disp_st;
			end
			rsa_pkg::ST_EVAL: begin
				if (min_mode_q && hit_q) begin
					// release this requester's references
					lo_d      = hit_key_q;
					have_lo_d = 1'b1;
					if (cur_q == rsa_pkg::SET_ERROR) begin
						if (err_q == rsa_pkg::RC_OK) err_d = rsa_pkg::RC_INVSTATE;
					end else if (total_q >= hit_refs_q) begin
						total_d      = total_q - hit_refs_q;
						wr.en        = 1'b1;
						wr.clr_valid = 1'b1;
						wr.key       = hit_key_q;
					end else begin
						cur_d = rsa_pkg::SET_ERROR;
						if (err_q == rsa_pkg::RC_OK) err_d = rsa_pkg::RC_INVSTATE;
					end
				end else if (min_mode_q) begin
					cur_d      = rs_cur;
					err_d      = rs_err;
					st_d       = rs_err;
					start_scan = rs_cont;
					min_mode_d = 1'b0;
				end else if (kind_q == rsa_pkg::KIND_REQUEST) begin
					priority if (hit_q && !allow_q) begin
						st_d = rsa_pkg::RC_ILLEGAL;
					end else if (total_q == '1) begin
						st_d = rsa_pkg::RC_NOROOM;
					end else if (total_q == 32'd0 && !tok_q) begin
						st_d = rsa_pkg::RC_XFAIL;
					end else if (!hit_q && !free_q) begin
						cur_d = rsa_pkg::SET_ERROR;
						st_d  = rsa_pkg::RC_NOROOM;
					end else begin
						wr.en        = 1'b1;
						wr.set_valid = 1'b1;
						wr.key       = id_q;
						wr.refs      = hit_q ? hit_refs_q + 32'd1 : 32'd1;
						wr_addr      = hit_q ? hit_idx_q : free_idx_q;
						total_d      = total_q + 32'd1;
						cur_d        = want_q;
						st_d         = rsa_pkg::RC_OK;
					end
				end else begin
					// release
					if (!hit_q) begin
						st_d = rsa_pkg::RC_ILLEGAL;
					end else begin
						if (rel_ok) begin
							total_d      = rel_total;
							wr.en        = 1'b1;
							wr.clr_valid = rel_refs == 32'd0;
							wr.key       = id_q;
							wr.refs      = rel_refs;
							st_d         = rsa_pkg::RC_OK;
						end else begin
							cur_d = rsa_pkg::SET_ERROR;
							st_d  = rsa_pkg::RC_INVSTATE;
						end
						if ((rel_ok ? cur_q != rsa_pkg::SET_DEFAULT : 1'b1) &&
							((rel_ok ? rel_total : total_q) == 32'd0)) begin
							if (tok_q) begin
								cur_d = rsa_pkg::SET_DEFAULT;
							end else if (rel_ok) begin
								st_d = rsa_pkg::RC_XFAIL;
							end
						end
					end
				end
			end
			rsa_pkg::ST_NOTE: begin
				start_scan = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= rsa_pkg::ST_IDLE;
			allow_q    <= 1'b0;
			cur_q      <= rsa_pkg::SET_DEFAULT;
			total_q    <= '0;
			err_q      <= rsa_pkg::RC_OK;
			st_q       <= rsa_pkg::RC_OK;
			cnt_q      <= '0;
			pend_s1    <= 1'b0;
			min_mode_q <= 1'b0;
			have_lo_q  <= 1'b0;
			from_req_q <= 1'b0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			state_q    <= state_d;
			cur_q      <= cur_d;
			total_q    <= total_d;
			err_q      <= err_d;
			st_q       <= st_d;
			min_mode_q <= min_mode_d;
			have_lo_q  <= have_lo_d;
			from_req_q <= from_req_d;
			if (cfg_wr_en) allow_q <= cfg_wr_data;
			// walk: issue reads at cnt_q, fold the entry from the registered read port
			pend_s1 <= (state_q == rsa_pkg::ST_SCAN) && (cnt_q < CNT_END);
			if (start_scan) begin
				cnt_q  <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else if (state_q == rsa_pkg::ST_SCAN) begin
				if (cnt_q < CNT_END) cnt_q <= cnt_q + 1'b1;
				if (pend_s1) begin
					if (min_mode_q) begin
						if (rd_valid && (!have_lo_q || rd_key > lo_q) &&
							(!hit_q || rd_key < hit_key_q)) begin
							hit_q <= 1'b1;
						end
					end else begin
						if (rd_valid && rd_key == id_q) hit_q <= 1'b1;
						if (!rd_valid && !free_q) free_q <= 1'b1;
					end
				end
			end
			if (out_free) begin
				out_v_q <= (state_q == rsa_pkg::ST_NOTE) || (state_q == rsa_pkg::ST_FINAL);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		lo_q   <= lo_d;
		idx_s1 <= cnt_q[AW-1:0];
		if (state_q == rsa_pkg::ST_IDLE && s_axis_tvalid) begin
			kind_q  <= s_axis_tuser;
			id_q    <= s_axis_tdata[63:0];
			want_q  <= s_axis_tdata[65:64];
			force_q <= s_axis_tdata[66];
			all_q   <= s_axis_tdata[67];
			fcb_q   <= s_axis_tdata[68];
			tok_q   <= s_axis_tdata[69];
		end
		if (state_q == rsa_pkg::ST_SCAN && pend_s1 && !start_scan) begin
			if (min_mode_q) begin
				if (rd_valid && (!have_lo_q || rd_key > lo_q) &&
					(!hit_q || rd_key < hit_key_q)) begin
					hit_idx_q  <= idx_s1;
					hit_key_q  <= rd_key;
					hit_refs_q <= rd_refs;
				end
			end else begin
				if (rd_valid && rd_key == id_q) begin
					hit_idx_q  <= idx_s1;
					hit_refs_q <= rd_refs;
				end
				if (!rd_valid && !free_q) free_idx_q <= idx_s1;
			end
		end
		if (out_free) begin
			out_notice_q <= state_q == rsa_pkg::ST_NOTE;
			out_last_q   <= state_q == rsa_pkg::ST_FINAL;
			out_id_q     <= (state_q == rsa_pkg::ST_NOTE) ? lo_q : 64'd0;
			out_st_q     <= (state_q == rsa_pkg::ST_NOTE) ? rsa_pkg::RC_OK : st_q;
			out_set_q    <= cur_q;
			out_tot_q    <= total_q;
		end
	end

	assign s_axis_tready = state_q == rsa_pkg::ST_IDLE;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tuser  = out_notice_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {3'd0, out_tot_q, out_set_q, out_st_q, out_id_q};

	// a notification never carries an error or closes the request
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[66:64] == rsa_pkg::RC_OK) && !m_axis_tlast)
		else $error("notification with status or last set");

	// walk counter stays within the table
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CNT_END)
		else $error("walk counter past table end");

	// the sequencer returns to idle only after posting a final result
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(s_axis_tready) |-> $past(state_q == rsa_pkg::ST_FINAL) && m_axis_tvalid && m_axis_tlast)
		else $error("idle without final result");

endmodule

// File: rtl/rsa_table.sv
// Requester table: key and count memories with a registered read port,
// plus per-entry valid flops. Depends on rsa_pkg.
module rsa_table #(
	parameter int unsigned ENTRIES = rsa_pkg::TABLE_ENTRIES,
	localparam int unsigned AW = $clog2(ENTRIES)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [AW-1:0]   rd_addr,
	output logic [63:0]     rd_key,
	output logic [31:0]     rd_refs,
	output logic            rd_valid,
	input  logic [AW-1:0]   wr_addr,
	input  rsa_pkg::tbl_wr_t wr
);

	logic [63:0]        key_mem [ENTRIES];
	logic [31:0]        refs_mem [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [63:0]        rd_key_q;
	logic [31:0]        rd_refs_q;
	logic               rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			key_mem[wr_addr]  <= wr.key;
			refs_mem[wr_addr] <= wr.refs;
		end
		rd_key_q  <= key_mem[rd_addr];
		rd_refs_q <= refs_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= valid_q[rd_addr];
			if (wr.en && wr.set_valid) begin
				valid_q[wr_addr] <= 1'b1;
			end else if (wr.en && wr.clr_valid) begin
				valid_q[wr_addr] <= 1'b0;
			end
		end
	end

	assign rd_key   = rd_key_q;
	assign rd_refs  = rd_refs_q;
	assign rd_valid = rd_valid_q;

endmodule

// File: bench/refcounted_setting_arbiter_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for refcounted_setting_arbiter: directed table, random phases, then a full table.
// Depends on rsa_pkg and the RTL of refcounted_setting_arbiter; a built-in predictor checks results.
module refcounted_setting_arbiter_tb;

	localparam int unsigned N_ENT = rsa_pkg::TABLE_ENTRIES;
	// longest item: a forced request whose reset walks a full table
	localparam int unsigned SETTLE = 2 * (N_ENT + 1) * (N_ENT + 3) + 40;
	localparam int unsigned LONG_HOLD = 300;
	localparam logic [1:0] KIND_BOGUS = 2'd3;

	typedef struct {
		logic [1:0]  kind;
		logic [63:0] rid;
		logic [1:0]  want;
		logic        force_req;
		logic        rel_all;
		logic        force_cb;
		logic        tok;
	} request_t;

	typedef struct {
		logic        notice;
		logic [63:0] evicted;
		logic [2:0]  status;
		logic [1:0]  setting;
		logic [31:0] total;
		logic        last;
	} outcome_t;

	typedef struct {
		request_t req;
		int       want_status;  // -1: left to the predictor
	} row_t;

	logic          clk;
	logic          arst_n;
	logic          cfg_wr_en;
	logic          cfg_wr_data;
	logic          s_axis_tvalid;
	logic          s_axis_tready;
	logic [71:0]   s_axis_tdata;
	logic [1:0]    s_axis_tuser;
	logic          m_axis_tvalid;
	logic          m_axis_tready;
	logic [103:0]  m_axis_tdata;
	logic          m_axis_tuser;
	logic          m_axis_tlast;

	refcounted_setting_arbiter uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	// shadow copy of the arbiter state
	logic [63:0] sh_key [N_ENT];
	logic [31:0] sh_refs [N_ENT];
	logic        sh_vld [N_ENT];
	logic [1:0]  sh_setting;
	logic [31:0] sh_total;
	logic        sh_recursive;

	outcome_t pending_results[$];
	logic [63:0] id_pool [12];
	row_t directed[$];

	int errors = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_notes = 0;
	bit idle_on = 1;
	bit hold_req = 0;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("*** FAILED ***");
		$finish;
	end

	task automatic note_result(input logic notice, input logic [63:0] id,
			input logic [2:0] status, input logic last);
		outcome_t o;
		o.notice = notice;
		o.evicted = id;
		o.status = status;
		o.setting = sh_setting;
		o.total = sh_total;
		o.last = last;
		pending_results.push_back(o);
	endtask

	function automatic int lookup_slot(input logic [63:0] id);
		for (int i = 0; i < N_ENT; i++)
			if (sh_vld[i] && sh_key[i] == id) return i;
		return -1;
	endfunction

	// walk every requester in ascending id order, releasing its references
	task automatic clear_all(input logic fcb, input logic tok, output logic [2:0] err);
		int order[N_ENT];
		bit taken[N_ENT];
		int n, best;
		logic [31:0] adj;
		err = rsa_pkg::RC_OK;
		n = 0;
		for (int i = 0; i < N_ENT; i++) taken[i] = 0;
		forever begin
			best = -1;
			for (int i = 0; i < N_ENT; i++)
				if (sh_vld[i] && !taken[i] && (best < 0 || sh_key[i] < sh_key[best]))
					best = i;
			if (best < 0) break;
			taken[best] = 1;
			order[n++] = best;
		end
		for (int j = 0; j < n; j++) begin
			int s;
			s = order[j];
			if (sh_setting == rsa_pkg::SET_ERROR) begin
				if (err == rsa_pkg::RC_OK) err = rsa_pkg::RC_INVSTATE;
			end else begin
				adj = sh_refs[s];
				if (sh_total >= adj) begin
					sh_total -= adj;
					sh_refs[s] = 0;
				end else begin
					sh_setting = rsa_pkg::SET_ERROR;
					if (err == rsa_pkg::RC_OK) err = rsa_pkg::RC_INVSTATE;
				end
				if (sh_refs[s] == 0) sh_vld[s] = 0;
			end
			note_result(1'b1, sh_key[s], rsa_pkg::RC_OK, 1'b0);
		end
		if (sh_total != 0) begin
			sh_setting = rsa_pkg::SET_ERROR;
			err = rsa_pkg::RC_INVSTATE;
		end
		if (fcb && err == rsa_pkg::RC_OK) begin
			if (tok) begin
				sh_setting = rsa_pkg::SET_DEFAULT;
			end else begin
				sh_setting = rsa_pkg::SET_ERROR;
				err = rsa_pkg::RC_XFAIL;
			end
		end
	endtask

	task automatic grant_request(input request_t r, output logic [2:0] st);
		int s;
		logic [2:0] sub;
		if (r.want != rsa_pkg::SET_ENABLED && r.want != rsa_pkg::SET_DISABLED) begin
			st = rsa_pkg::RC_BADARG;
			return;
		end
		if (sh_setting == rsa_pkg::SET_ERROR) begin
			st = rsa_pkg::RC_INVSTATE;
			return;
		end
		if (sh_total > 0 && r.want != sh_setting) begin
			if (!r.force_req) begin
				st = rsa_pkg::RC_INUSE;
				return;
			end
			clear_all(1'b0, r.tok, sub);
			if (sub != rsa_pkg::RC_OK) begin
				st = sub;
				return;
			end
		end
		s = lookup_slot(r.rid);
		if (s >= 0 && sh_refs[s] > 0 && !sh_recursive) begin
			st = rsa_pkg::RC_ILLEGAL;
			return;
		end
		if (sh_total == 32'hFFFF_FFFF) begin
			st = rsa_pkg::RC_NOROOM;
		end else if (sh_total == 0 && !r.tok) begin
			st = rsa_pkg::RC_XFAIL;
		end else begin
			if (s < 0) begin
				for (int i = 0; i < N_ENT; i++)
					if (!sh_vld[i]) begin
						s = i;
						break;
					end
				if (s < 0) begin
					sh_setting = rsa_pkg::SET_ERROR;
					st = rsa_pkg::RC_NOROOM;
					return;
				end
				sh_vld[s] = 1;
				sh_key[s] = r.rid;
				sh_refs[s] = 0;
			end
			sh_refs[s]++;
			sh_total++;
			sh_setting = r.want;
			st = rsa_pkg::RC_OK;
		end
		if (s >= 0 && sh_vld[s] && sh_refs[s] == 0) sh_vld[s] = 0;
	endtask

	task automatic drop_refs(input request_t r, output logic [2:0] st);
		int s;
		logic [31:0] adj;
		st = rsa_pkg::RC_OK;
		if (sh_setting == rsa_pkg::SET_ERROR) begin
			st = rsa_pkg::RC_INVSTATE;
			return;
		end
		s = lookup_slot(r.rid);
		if (s < 0) begin
			st = rsa_pkg::RC_ILLEGAL;
			return;
		end
		adj = r.rel_all ? sh_refs[s] : (sh_refs[s] > 0 ? 32'd1 : 32'd0);
		if (sh_total >= adj) begin
			sh_total -= adj;
			sh_refs[s] -= adj;
		end else begin
			sh_setting = rsa_pkg::SET_ERROR;
			st = rsa_pkg::RC_INVSTATE;
		end
		if (sh_refs[s] == 0) sh_vld[s] = 0;
		if (sh_setting != rsa_pkg::SET_DEFAULT && sh_total == 0) begin
			if (r.tok) sh_setting = rsa_pkg::SET_DEFAULT;
			else if (st == rsa_pkg::RC_OK) st = rsa_pkg::RC_XFAIL;
		end
	endtask

	// advance the shadow state by one request and queue what it must produce
	task automatic predict_arbiter(input request_t r, output logic [2:0] st);
		case (r.kind)
			rsa_pkg::KIND_REQUEST: grant_request(r, st);
			rsa_pkg::KIND_RELEASE: drop_refs(r, st);
			rsa_pkg::KIND_RESET:   clear_all(r.force_cb, r.tok, st);
			default:               st = rsa_pkg::RC_BADARG;
		endcase
		note_result(1'b0, 64'd0, st, 1'b1);
	endtask

	// offer one request, optionally after an idle burst; returns once it is taken
	task automatic send_request(input request_t r, output logic [2:0] st);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= r.kind;
		s_axis_tdata <= {2'b00, r.tok, r.force_cb, r.rel_all, r.force_req, r.want, r.rid};
		// inputs move only at rising edges, so the value seen at the falling edge is the one
		// the next rising edge samples
		do @(negedge clk); while (!s_axis_tready);
		predict_arbiter(r, st);
		n_sent++;
		@(posedge clk);
	endtask

	// drain outstanding results, let the block settle, then write allow_recursive
	task automatic write_recursive(input logic v);
		s_axis_tvalid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (SETTLE) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sh_recursive = v;
	endtask

	function automatic request_t mk(input logic [1:0] kind, input logic [63:0] rid,
			input logic [1:0] want, input logic fr, input logic ra, input logic fcb,
			input logic tok);
		request_t r;
		r.kind = kind;
		r.rid = rid;
		r.want = want;
		r.force_req = fr;
		r.rel_all = ra;
		r.force_cb = fcb;
		r.tok = tok;
		return r;
	endfunction

	function automatic void add_row(input request_t r, input int st);
		row_t w;
		w.req = r;
		w.want_status = st;
		directed.push_back(w);
	endfunction

	function automatic request_t random_request();
		request_t r;
		int pick;
		r.rid = id_pool[$urandom_range(0, 11)];
		r.want = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3))
			: 2'($urandom_range(1, 2));
		r.force_req = 1'($urandom_range(0, 1));
		r.rel_all = 1'($urandom_range(0, 1));
		r.force_cb = $urandom_range(0, 3) != 0;
		r.tok = $urandom_range(0, 9) != 0;
		pick = $urandom_range(0, 99);
		if (pick < 48) r.kind = rsa_pkg::KIND_REQUEST;
		else if (pick < 84) r.kind = rsa_pkg::KIND_RELEASE;
		else if (pick < 96) r.kind = rsa_pkg::KIND_RESET;
		else r.kind = KIND_BOGUS;
		// a stranger id on a release exercises the unknown-requester path
		if (r.kind == rsa_pkg::KIND_RELEASE && $urandom_range(0, 9) == 0)
			r.rid = {$urandom, $urandom};
		return r;
	endfunction

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 7) - 1) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// checker: outputs are stable at the falling edge ahead of the accepting rising edge
	always @(negedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$error("result with nothing expected: tdata=%h", m_axis_tdata);
				errors++;
			end else begin
				outcome_t e;
				e = pending_results.pop_front();
				n_checked++;
				if (e.notice) n_notes++;
				if (m_axis_tuser !== e.notice) begin
					$error("notice: expected %0d, got %0d", e.notice, m_axis_tuser);
					errors++;
				end
				if (m_axis_tdata[63:0] !== e.evicted) begin
					$error("evicted_requester: expected %h, got %h", e.evicted,
						m_axis_tdata[63:0]);
					errors++;
				end
				if (m_axis_tdata[66:64] !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, m_axis_tdata[66:64]);
					errors++;
				end
				if (m_axis_tdata[68:67] !== e.setting) begin
					$error("setting_state: expected %0d, got %0d", e.setting,
						m_axis_tdata[68:67]);
					errors++;
				end
				if (m_axis_tdata[100:69] !== e.total) begin
					$error("total_refs: expected %0d, got %0d", e.total,
						m_axis_tdata[100:69]);
					errors++;
				end
				if (m_axis_tlast !== e.last) begin
					$error("last: expected %0d, got %0d", e.last, m_axis_tlast);
					errors++;
				end
			end
		end
	end

	initial begin
		logic [2:0] st;
		logic [63:0] ida, idb, idf;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = rsa_pkg::KIND_REQUEST;
		arst_n = 1'b0;
		for (int i = 0; i < N_ENT; i++) begin
			sh_key[i] = '0;
			sh_refs[i] = '0;
			sh_vld[i] = 0;
		end
		sh_setting = rsa_pkg::SET_DEFAULT;
		sh_total = '0;
		sh_recursive = 0;

		id_pool[0] = 64'd0;
		id_pool[1] = '1;
		for (int i = 2; i < 12; i++) id_pool[i] = {$urandom, $urandom};
		ida = id_pool[2];
		idb = id_pool[3];
		idf = '1;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, allow_recursive still at its reset value
		add_row(mk(rsa_pkg::KIND_RELEASE, 64'd0, rsa_pkg::SET_DEFAULT, 0, 0, 0, 1),
			rsa_pkg::RC_ILLEGAL);
		add_row(mk(rsa_pkg::KIND_REQUEST, 64'd0, rsa_pkg::SET_DEFAULT, 0, 0, 0, 1),
			rsa_pkg::RC_BADARG);
		add_row(mk(rsa_pkg::KIND_REQUEST, 64'd0, rsa_pkg::SET_ERROR, 1, 1, 1, 1),
			rsa_pkg::RC_BADARG);
		add_row(mk(KIND_BOGUS, idf, rsa_pkg::SET_ENABLED, 1, 1, 1, 1), rsa_pkg::RC_BADARG);
		add_row(mk(rsa_pkg::KIND_REQUEST, 64'd0, rsa_pkg::SET_ENABLED, 0, 0, 0, 0),
			rsa_pkg::RC_XFAIL);
		add_row(mk(rsa_pkg::KIND_REQUEST, 64'd0, rsa_pkg::SET_ENABLED, 0, 0, 0, 1),
			rsa_pkg::RC_OK);
		add_row(mk(rsa_pkg::KIND_REQUEST, 64'd0, rsa_pkg::SET_ENABLED, 0, 0, 0, 1),
			rsa_pkg::RC_ILLEGAL);
		add_row(mk(rsa_pkg::KIND_REQUEST, idf, rsa_pkg::SET_DISABLED, 0, 0, 0, 1),
			rsa_pkg::RC_INUSE);
		add_row(mk(rsa_pkg::KIND_REQUEST, idf, rsa_pkg::SET_ENABLED, 0, 0, 0, 1),
			rsa_pkg::RC_OK);
		add_row(mk(rsa_pkg::KIND_REQUEST, idf, rsa_pkg::SET_DISABLED, 1, 0, 0, 1), -1);
		add_row(mk(rsa_pkg::KIND_RELEASE, idf, rsa_pkg::SET_DEFAULT, 0, 1, 0, 0),
			rsa_pkg::RC_XFAIL);
		add_row(mk(rsa_pkg::KIND_RELEASE, 64'd0, rsa_pkg::SET_DEFAULT, 0, 0, 0, 1),
			rsa_pkg::RC_ILLEGAL);
		add_row(mk(rsa_pkg::KIND_REQUEST, 64'd0, rsa_pkg::SET_DISABLED, 0, 0, 0, 1),
			rsa_pkg::RC_OK);
		add_row(mk(rsa_pkg::KIND_RELEASE, 64'd0, rsa_pkg::SET_DEFAULT, 0, 0, 0, 1),
			rsa_pkg::RC_OK);
		add_row(mk(rsa_pkg::KIND_RESET, 64'd0, rsa_pkg::SET_DEFAULT, 0, 0, 1, 0),
			rsa_pkg::RC_XFAIL);
		add_row(mk(rsa_pkg::KIND_REQUEST, 64'd0, rsa_pkg::SET_ENABLED, 0, 0, 0, 1),
			rsa_pkg::RC_INVSTATE);
		add_row(mk(rsa_pkg::KIND_RELEASE, 64'd0, rsa_pkg::SET_DEFAULT, 0, 1, 0, 1),
			rsa_pkg::RC_INVSTATE);
		add_row(mk(rsa_pkg::KIND_RESET, 64'd0, rsa_pkg::SET_DEFAULT, 0, 0, 1, 1),
			rsa_pkg::RC_OK);
		add_row(mk(rsa_pkg::KIND_REQUEST, ida, rsa_pkg::SET_ENABLED, 0, 0, 0, 1),
			rsa_pkg::RC_OK);
		add_row(mk(rsa_pkg::KIND_REQUEST, idb, rsa_pkg::SET_ENABLED, 0, 0, 0, 1),
			rsa_pkg::RC_OK);
		add_row(mk(rsa_pkg::KIND_REQUEST, idf, rsa_pkg::SET_ENABLED, 0, 0, 0, 1),
			rsa_pkg::RC_OK);
		add_row(mk(rsa_pkg::KIND_RESET, 64'd0, rsa_pkg::SET_DEFAULT, 0, 0, 0, 1), -1);
		add_row(mk(rsa_pkg::KIND_RESET, 64'd0, rsa_pkg::SET_DEFAULT, 0, 0, 1, 1),
			rsa_pkg::RC_OK);

		foreach (directed[i]) begin
			send_request(directed[i].req, st);
			if (directed[i].want_status >= 0 && st != 3'(directed[i].want_status)) begin
				$error("status: expected %0d, got %0d (table row %0d)",
					directed[i].want_status, st, i);
				errors++;
			end
		end

		// random phases: recursion on, off, on; the first starts with a long receiver hold
		for (int ph = 0; ph < 3; ph++) begin
			write_recursive(ph != 1);
			if (ph == 0) hold_req = 1;
			if (ph == 2) idle_on = 0;
			repeat (35) send_request(random_request(), st);
		end

		// fill the table past its size, then confirm the error state sticks
		send_request(mk(rsa_pkg::KIND_RESET, 64'd0, rsa_pkg::SET_DEFAULT, 0, 0, 1, 1), st);
		for (int i = 0; i <= N_ENT; i++)
			send_request(mk(rsa_pkg::KIND_REQUEST, {32'hA5C3_0000, 32'(i)},
				rsa_pkg::SET_DISABLED, 0, 0, 0, 1), st);
		send_request(mk(rsa_pkg::KIND_RESET, 64'd0, rsa_pkg::SET_DEFAULT, 0, 0, 1, 1), st);
		send_request(mk(rsa_pkg::KIND_RELEASE, {32'hA5C3_0000, 32'd0}, rsa_pkg::SET_DEFAULT,
			0, 1, 0, 1), st);
		s_axis_tvalid <= 1'b0;

		wait (pending_results.size() == 0);
		repeat (SETTLE) @(posedge clk);
		$display("Sent %0d requests (directed, three random phases, full table);",
			n_sent);
		$display("checked %0d results, %0d of them reset notices.", n_checked, n_notes);
		if (errors == 0 && pending_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: files.f
rtl/rsa_pkg.sv
rtl/rsa_table.sv
rtl/refcounted_setting_arbiter.sv
bench/refcounted_setting_arbiter_tb.sv
